// ----- sv/sfd_pkg.sv -----
// shared types and constants for the serial frame deframer
package sfd_pkg;

  // framing bytes and limits
  localparam logic [7:0] START_REQ = 8'h10;
  localparam logic [7:0] START_REP = 8'h20;
  localparam logic [7:0] MIN_LEN   = 8'd6;

  // gap limit reset values in ticks
  localparam logic [31:0] START_GAP_RESET = 32'(1193 * 250);
  localparam logic [31:0] BYTE_GAP_RESET  = 32'(1193 * 25);

  // phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_XOR  = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_GAP  = 3'd3;
  localparam logic [2:0] ST_CHAN = 3'd4;

  // item kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // register indexes
  localparam logic REG_START_GAP = 1'b0;
  localparam logic REG_BYTE_GAP  = 1'b1;

  // one received byte
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [7:0]  line_channel;
    logic [31:0] timestamp;
  } sfd_byte_t;

  // one result item
  typedef struct packed {
    logic       item_kind;
    logic       is_reply;
    logic [7:0] station_address;
    logic [7:0] message_type;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] frame_status;
    logic       last_of_frame;
  } sfd_result_t;

endpackage

// ----- sv/sfd_if.sv -----
// request channel interfaces for received bytes and frame results
interface sfd_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [7:0]  line_channel;
  logic [31:0] timestamp;

  modport source (output valid, output byte_value, output line_channel, output timestamp,
                  input ready);
  modport sink (input valid, input byte_value, input line_channel, input timestamp,
                output ready);
endinterface

interface sfd_result_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic       is_reply;
  logic [7:0] station_address;
  logic [7:0] message_type;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [2:0] frame_status;
  logic       last_of_frame;

  modport source (output valid, output item_kind, output is_reply, output station_address,
                  output message_type, output payload_byte, output payload_index,
                  output frame_status, output last_of_frame, input ready);
  modport sink (input valid, input item_kind, input is_reply, input station_address,
                input message_type, input payload_byte, input payload_index,
                input frame_status, input last_of_frame, output ready);
endinterface

// ----- sv/serial_frame_deframer_xor_check.sv -----
// serial frame deframer with running xor check, top level
// a request's result passes the input register, then the result register; a request that
// yields no result still takes one slot; one byte request is taken per cycle unless the
// result register stalls; the input register advances whenever the result register is empty
// or being taken; reset (rst, synchronous, active high) returns to hunting, empties both
// registers and restores both gap limits to their default values
module serial_frame_deframer_xor_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sfd_byte_if.sink    byte_in,
  sfd_result_if.source result_out
);
  import sfd_pkg::*;

  // configuration registers
  logic [31:0] start_gap_ticks;
  logic [31:0] byte_gap_ticks;

  // input register
  logic      in_valid;
  sfd_byte_t in_item;

  // result register
  logic        out_valid;
  sfd_result_t out_item;

  // frame state
  logic [1:0]  phase;
  logic [7:0]  frame_channel;
  logic [31:0] last_byte_time;
  logic [7:0]  bytes_counted;
  logic [7:0]  frame_length;
  logic [7:0]  running_xor;
  logic        reply_flag;
  logic [7:0]  held_address;
  logic [7:0]  held_type;

  logic [1:0]  phase_next;
  logic [7:0]  frame_channel_next;
  logic [31:0] last_byte_time_next;
  logic [7:0]  bytes_counted_next;
  logic [7:0]  frame_length_next;
  logic [7:0]  running_xor_next;
  logic        reply_flag_next;
  logic [7:0]  held_address_next;
  logic [7:0]  held_type_next;

  logic        has_result;
  sfd_result_t result_next;
  logic        advance;

  logic        in_frame;
  logic        is_start;
  logic        chan_bad;
  logic        gap_bad;
  logic [31:0] gap;
  logic [31:0] gap_limit;
  logic [7:0]  pos;
  logic [7:0]  count_inc;

  // apb register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BYTE_GAP) ? byte_gap_ticks : start_gap_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_gap_ticks <= START_GAP_RESET;
      byte_gap_ticks  <= BYTE_GAP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_START_GAP: start_gap_ticks <= pwdata;
        REG_BYTE_GAP:  byte_gap_ticks  <= pwdata;
        default: ;
      endcase
    end
  end

  // handshake control
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_item.byte_value   <= byte_in.byte_value;
      in_item.line_channel <= byte_in.line_channel;
      in_item.timestamp    <= byte_in.timestamp;
    end
  end

  // frame checks on the held byte
  assign in_frame  = (phase == PH_LEN) || (phase == PH_BODY);
  assign is_start  = (in_item.byte_value == START_REQ) || (in_item.byte_value == START_REP);
  assign chan_bad  = in_item.line_channel != frame_channel;
  assign gap       = in_item.timestamp - last_byte_time;
  assign gap_limit = (phase == PH_LEN) ? start_gap_ticks : byte_gap_ticks;
  assign gap_bad   = gap > gap_limit;
  assign pos       = bytes_counted;
  assign count_inc = bytes_counted + 8'd1;

  // next state and result for the held byte
  always_comb begin
    phase_next          = phase;
    frame_channel_next  = frame_channel;
    last_byte_time_next = last_byte_time;
    bytes_counted_next  = bytes_counted;
    frame_length_next   = frame_length;
    running_xor_next    = running_xor;
    reply_flag_next     = reply_flag;
    held_address_next   = held_address;
    held_type_next      = held_type;
    has_result          = 1'b0;

    // status item by default, data fields zero
    result_next.item_kind       = KIND_STATUS;
    result_next.is_reply        = reply_flag;
    result_next.station_address = held_address;
    result_next.message_type    = held_type;
    result_next.payload_byte    = 8'd0;
    result_next.payload_index   = 8'd0;
    result_next.frame_status    = ST_OK;
    result_next.last_of_frame   = 1'b1;

    if (!in_frame || chan_bad || gap_bad) begin
      // hunting, or an abort that reconsiders this byte as a start
      if (in_frame) begin
        has_result               = 1'b1;
        result_next.frame_status = chan_bad ? ST_CHAN : ST_GAP;
      end
      phase_next = PH_HUNT;
      if (is_start) begin
        phase_next          = PH_LEN;
        reply_flag_next     = in_item.byte_value == START_REP;
        frame_channel_next  = in_item.line_channel;
        last_byte_time_next = in_item.timestamp;
        running_xor_next    = in_item.byte_value;
        bytes_counted_next  = 8'd1;
        frame_length_next   = 8'd0;
        held_address_next   = 8'd0;
        held_type_next      = 8'd0;
      end
    end else if (phase == PH_LEN) begin
      last_byte_time_next = in_item.timestamp;
      if (in_item.byte_value < MIN_LEN) begin
        has_result               = 1'b1;
        result_next.frame_status = ST_SIZE;
        phase_next               = PH_HUNT;
      end else begin
        frame_length_next  = in_item.byte_value;
        running_xor_next   = running_xor ^ in_item.byte_value;
        bytes_counted_next = 8'd2;
        phase_next         = PH_BODY;
      end
    end else begin
      last_byte_time_next = in_item.timestamp;
      bytes_counted_next  = count_inc;
      if (count_inc == frame_length) begin
        // end byte closes the frame
        has_result               = 1'b1;
        result_next.frame_status = (running_xor == 8'd0) ? ST_OK : ST_XOR;
        phase_next               = PH_HUNT;
      end else begin
        running_xor_next = running_xor ^ in_item.byte_value;
        if (pos == 8'd2) begin
          held_address_next = in_item.byte_value;
        end else if (pos == 8'd3) begin
          held_type_next = in_item.byte_value;
        end else begin
          has_result                = 1'b1;
          result_next.item_kind     = KIND_DATA;
          result_next.payload_byte  = in_item.byte_value;
          result_next.payload_index = pos - 8'd4;
          result_next.last_of_frame = 1'b0;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      frame_channel  <= 8'd0;
      last_byte_time <= 32'd0;
      bytes_counted  <= 8'd0;
      frame_length   <= 8'd0;
      running_xor    <= 8'd0;
      reply_flag     <= 1'b0;
      held_address   <= 8'd0;
      held_type      <= 8'd0;
    end else if (advance) begin
      phase          <= phase_next;
      frame_channel  <= frame_channel_next;
      last_byte_time <= last_byte_time_next;
      bytes_counted  <= bytes_counted_next;
      frame_length   <= frame_length_next;
      running_xor    <= running_xor_next;
      reply_flag     <= reply_flag_next;
      held_address   <= held_address_next;
      held_type      <= held_type_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_item <= result_next;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.item_kind       = out_item.item_kind;
  assign result_out.is_reply        = out_item.is_reply;
  assign result_out.station_address = out_item.station_address;
  assign result_out.message_type    = out_item.message_type;
  assign result_out.payload_byte    = out_item.payload_byte;
  assign result_out.payload_index   = out_item.payload_index;
  assign result_out.frame_status    = out_item.frame_status;
  assign result_out.last_of_frame   = out_item.last_of_frame;

`ifndef SYNTH
  // the unused phase code is never entered
  assert property (@(posedge clk) disable iff (rst) phase != 2'd3)
    else $error("deframer entered unused phase code");

  // inside a frame body the count stays short of the length
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> (bytes_counted >= 8'd2) && (bytes_counted < frame_length)
                         && (frame_length >= MIN_LEN))
    else $error("frame body count out of range");

  // a held byte waiting on a stalled result leaves the frame state alone
  assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !result_out.ready |=> $stable(phase) && $stable(bytes_counted))
    else $error("frame state moved while the result register was stalled");

  // a status result always closes the frame
  assert property (@(posedge clk) disable iff (rst)
    advance && has_result && result_next.item_kind == KIND_STATUS |=> phase != PH_BODY)
    else $error("frame body continued after a status result");
`endif

endmodule

// ----- bench/sfd_checker.sv -----
// frame deframer checker: predicts results from accepted byte requests and compares them
module sfd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  sfd_byte_if         bytes,
  sfd_result_if       results,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // gap limits as last written
  logic [31:0] start_gap;
  logic [31:0] body_gap;

  // deframer state
  logic [1:0]  phase;
  logic [7:0]  frame_chan;
  logic [31:0] last_time;
  logic [7:0]  count;
  logic [7:0]  length;
  logic [7:0]  xsum;
  logic        reply;
  logic [7:0]  held_addr;
  logic [7:0]  held_type;

  // results owed by the block, oldest first
  sfd_result_t frame_items_due[$];

  // status item closing the current frame
  function automatic sfd_result_t frame_end(input logic [2:0] st);
    sfd_result_t r;
    r = '0;
    r.item_kind = KIND_STATUS;
    r.is_reply = reply;
    r.station_address = held_addr;
    r.message_type = held_type;
    r.frame_status = st;
    r.last_of_frame = 1'b1;
    return r;
  endfunction

  // go back to hunting, or open a new frame when the byte is a start byte
  function automatic void hunt_for_start(input sfd_byte_t in);
    phase = PH_HUNT;
    if (in.byte_value == START_REQ || in.byte_value == START_REP) begin
      phase = PH_LEN;
      reply = (in.byte_value == START_REP);
      frame_chan = in.line_channel;
      last_time = in.timestamp;
      xsum = in.byte_value;
      count = 8'd1;
      length = '0;
      held_addr = '0;
      held_type = '0;
    end
  endfunction

  // one byte through the deframer; returns 1 when it yields a result
  function automatic bit deframe(input sfd_byte_t in, output sfd_result_t r);
    logic [31:0] gap;
    logic [31:0] limit;
    logic [7:0]  pos;
    r = '0;
    if (phase != PH_LEN && phase != PH_BODY) begin
      hunt_for_start(in);
      return 1'b0;
    end
    gap = in.timestamp - last_time;
    limit = (phase == PH_LEN) ? start_gap : body_gap;
    // channel change wins over a late byte
    if (in.line_channel != frame_chan) begin
      r = frame_end(ST_CHAN);
      hunt_for_start(in);
      return 1'b1;
    end
    if (gap > limit) begin
      r = frame_end(ST_GAP);
      hunt_for_start(in);
      return 1'b1;
    end
    last_time = in.timestamp;
    // length byte
    if (phase == PH_LEN) begin
      if (in.byte_value < MIN_LEN) begin
        r = frame_end(ST_SIZE);
        phase = PH_HUNT;
        return 1'b1;
      end
      length = in.byte_value;
      xsum ^= in.byte_value;
      count = 8'd2;
      phase = PH_BODY;
      return 1'b0;
    end
    // body byte, the end byte closes the frame
    pos = count;
    count = count + 8'd1;
    if (count == length) begin
      r = frame_end((xsum == 8'd0) ? ST_OK : ST_XOR);
      phase = PH_HUNT;
      return 1'b1;
    end
    xsum ^= in.byte_value;
    if (pos == 8'd2) begin
      held_addr = in.byte_value;
      return 1'b0;
    end
    if (pos == 8'd3) begin
      held_type = in.byte_value;
      return 1'b0;
    end
    r.item_kind = KIND_DATA;
    r.is_reply = reply;
    r.station_address = held_addr;
    r.message_type = held_type;
    r.payload_byte = in.byte_value;
    r.payload_index = pos - 8'd4;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    sfd_result_t got;
    sfd_result_t want;
    sfd_result_t next_item;
    sfd_byte_t   in;
    if (rst) begin
      failures = 0;
      start_gap = START_GAP_RESET;
      body_gap = BYTE_GAP_RESET;
      phase = PH_HUNT;
      frame_chan = '0;
      last_time = '0;
      count = '0;
      length = '0;
      xsum = '0;
      reply = 1'b0;
      held_addr = '0;
      held_type = '0;
      frame_items_due.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_START_GAP) start_gap = pwdata;
        else body_gap = pwdata;
      end
      // result requests against the oldest prediction
      if (results.valid && results.ready) begin
        got = '{item_kind: results.item_kind, is_reply: results.is_reply,
                station_address: results.station_address,
                message_type: results.message_type, payload_byte: results.payload_byte,
                payload_index: results.payload_index, frame_status: results.frame_status,
                last_of_frame: results.last_of_frame};
        if (frame_items_due.size() == 0) begin
          failures++;
          $display("%0t: result with nothing expected, expected none got %h", $time, got);
        end else begin
          want = frame_items_due.pop_front();
          check_field("item_kind", 8'(want.item_kind), 8'(got.item_kind));
          check_field("is_reply", 8'(want.is_reply), 8'(got.is_reply));
          check_field("station_address", want.station_address, got.station_address);
          check_field("message_type", want.message_type, got.message_type);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("payload_index", want.payload_index, got.payload_index);
          check_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
          check_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
        end
      end
      // byte requests into the predictor
      if (bytes.valid && bytes.ready) begin
        in = '{byte_value: bytes.byte_value, line_channel: bytes.line_channel,
               timestamp: bytes.timestamp};
        if (deframe(in, next_item)) frame_items_due.push_back(next_item);
      end
    end
    pending = frame_items_due.size();
  end

endmodule

// ----- bench/tb_serial_frame_deframer_xor_check.sv -----
// testbench top for the serial frame deframer: stimulus, idling and verdict
module tb_serial_frame_deframer_xor_check;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {FLAW_NONE, FLAW_XOR, FLAW_SHORT, FLAW_CHAN, FLAW_GAP, FLAW_CUT} frame_flaw_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          failures;
  int          pending;
  int          idle_cycles;

  // stimulus side copies of time and gap limits
  logic [31:0] now;
  logic [31:0] cfg_start_gap;
  logic [31:0] cfg_body_gap;
  int unsigned bytes_put;

  sfd_byte_if   bytes_if ();
  sfd_result_if results_if ();

  serial_frame_deframer_xor_check dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .byte_in(bytes_if),
    .result_out(results_if)
  );

  sfd_checker scoreboard (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .bytes(bytes_if),
    .results(results_if),
    .failures(failures),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one byte request; called and returning at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic [7:0] ch, input logic [31:0] dt);
    int unsigned idle;
    idle = (bytes_put % 64 < 16) ? 0 : $urandom_range(6);
    now = now + dt;
    if (idle > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.byte_value <= b;
    bytes_if.line_channel <= ch;
    bytes_if.timestamp <= now;
    do @(posedge clk); while (!bytes_if.ready);
    bytes_put++;
    @(negedge clk);
  endtask

  // hold the sender until every owed result is out and the pipeline is empty
  task automatic drain();
    bytes_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_START_GAP) cfg_start_gap = value;
    else cfg_body_gap = value;
  endtask

  task automatic set_gaps(input logic [31:0] start_limit, input logic [31:0] body_limit);
    drain();
    write_reg(REG_START_GAP, start_limit);
    write_reg(REG_BYTE_GAP, body_limit);
  endtask

  // one frame with random content and an optional defect; n counts bytes sent
  task automatic send_frame(input logic [7:0] len, input frame_flaw_t flaw, output int n);
    logic [7:0]  ch;
    logic [7:0]  b;
    logic [7:0]  xsum;
    logic [31:0] dt;
    logic [31:0] limit;
    int          cut;
    frame_flaw_t how;
    ch = 8'($urandom);
    xsum = '0;
    n = 0;
    how = flaw;
    cut = (how == FLAW_CUT) ? $urandom_range(len - 1, 2) : $urandom_range(len - 1, 1);
    for (int p = 0; p < len; p++) begin
      limit = (p == 1) ? cfg_start_gap : cfg_body_gap;
      if (p == 0) b = $urandom_range(1) ? START_REP : START_REQ;
      else if (p == 1) b = (how == FLAW_SHORT) ? 8'($urandom_range(MIN_LEN - 1)) : len;
      else if (p == len - 2) b = (how == FLAW_XOR) ? xsum ^ 8'($urandom_range(255, 1)) : xsum;
      else b = 8'($urandom);
      // time step: anything while hunting, else mostly inside the limit
      if (p == 0) dt = $urandom;
      else if (limit == 32'hFFFF_FFFF) dt = $urandom;
      else begin
        case ($urandom_range(3))
          0: dt = limit;
          1: dt = $urandom_range(limit);
          default: dt = $urandom_range((limit < 32'd1000) ? limit : 32'd1000);
        endcase
      end
      if (p == cut && how == FLAW_CUT) break;
      if (p == cut && how == FLAW_GAP && limit == 32'hFFFF_FFFF) how = FLAW_CHAN;
      // abort byte, sometimes a start byte that opens the next frame
      if (p == cut && (how == FLAW_CHAN || how == FLAW_GAP)) begin
        if ($urandom_range(3) == 0) b = $urandom_range(1) ? START_REP : START_REQ;
        if (how == FLAW_CHAN) ch = ch ^ 8'($urandom_range(255, 1));
        else dt = limit + 32'd1 +
                  ($urandom_range(1) ? 32'd0 : $urandom_range(32'hFFFF_FFFE - limit));
      end
      put_byte(b, ch, dt);
      n++;
      xsum ^= b;
      if (how == FLAW_SHORT && p == 1) break;
      if (p == cut && (how == FLAW_CHAN || how == FLAW_GAP)) break;
    end
  endtask

  // mostly well formed frames, some defects, some line noise between them
  task automatic run_random(input int target, input bit with_long);
    int          sent;
    int          n;
    int unsigned r;
    logic [7:0]  b;
    logic [7:0]  len;
    frame_flaw_t flaw;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          do b = 8'($urandom); while (b == START_REQ || b == START_REP);
          put_byte(b, 8'($urandom), $urandom);
        end
      end
      if (with_long && sent >= target / 5) begin
        with_long = 1'b0;
        send_frame(8'd255, FLAW_NONE, n);
      end else begin
        len = ($urandom_range(7) == 0) ? 8'($urandom_range(60, 25))
                                       : 8'($urandom_range(24, MIN_LEN));
        r = $urandom_range(99);
        if (r < 64) flaw = FLAW_NONE;
        else if (r < 72) flaw = FLAW_XOR;
        else if (r < 79) flaw = FLAW_SHORT;
        else if (r < 86) flaw = FLAW_CHAN;
        else if (r < 93) flaw = FLAW_GAP;
        else flaw = FLAW_CUT;
        send_frame(len, flaw, n);
      end
      sent += n;
      if ($urandom_range(24) == 0) drain();
    end
  endtask

  // result side ready with random stalls and stall-free stretches
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    results_if.ready = 1'b0;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = (taken % 48 < 12) ? 0 : $urandom_range(6);
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      taken++;
      @(negedge clk);
    end
  end

  // watchdog on cycles with no request moving on any port
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (bytes_if.valid && bytes_if.ready) ||
          (results_if.valid && results_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bytes_if.valid = 1'b0;
    bytes_if.byte_value = '0;
    bytes_if.line_channel = '0;
    bytes_if.timestamp = '0;
    now = $urandom;
    cfg_start_gap = START_GAP_RESET;
    cfg_body_gap = BYTE_GAP_RESET;
    bytes_put = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // noise while hunting is dropped
    put_byte(8'h00, 8'h00, 32'd0);
    put_byte(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    // length below the minimum
    put_byte(START_REQ, 8'h00, $urandom);
    put_byte(MIN_LEN - 8'd1, 8'h00, 32'd0);
    // shortest good frame across the timestamp wrap, gaps right at their limits
    now = 32'hFFFF_FFF0;
    put_byte(START_REP, 8'hFF, 32'd0);
    put_byte(MIN_LEN, 8'hFF, cfg_start_gap);
    put_byte(8'hFF, 8'hFF, cfg_body_gap);
    put_byte(8'h00, 8'hFF, 32'd0);
    put_byte(START_REP ^ MIN_LEN ^ 8'hFF, 8'hFF, cfg_body_gap);
    put_byte(8'hFF, 8'hFF, 32'd1);
    // channel abort on a reply start, then a late request start, then bad size
    put_byte(START_REQ, 8'h01, $urandom);
    put_byte(8'd6, 8'h01, 32'd0);
    put_byte(START_REP, 8'h02, 32'd0);
    put_byte(START_REQ, 8'h02, cfg_start_gap + 32'd1);
    put_byte(8'h00, 8'h02, 32'd0);
    // frame with a wrong check byte
    put_byte(START_REQ, 8'h80, $urandom);
    put_byte(8'd7, 8'h80, 32'd5);
    put_byte(8'hA5, 8'h80, cfg_body_gap);
    put_byte(8'h5A, 8'h80, 32'd3);
    put_byte(8'h00, 8'h80, 32'd0);
    put_byte(8'h01, 8'h80, 32'd1);
    put_byte(8'hEE, 8'h80, 32'd2);
    // late body byte
    put_byte(START_REP, 8'h7F, $urandom);
    put_byte(8'd200, 8'h7F, 32'd0);
    put_byte(8'h33, 8'h7F, cfg_body_gap + 32'd1);

    // random frames under several gap settings
    set_gaps(32'd0, 32'd0);
    run_random(65, 1'b0);
    set_gaps(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(65, 1'b0);
    set_gaps($urandom_range(3000, 1), $urandom_range(300, 1));
    run_random(65, 1'b0);
    set_gaps(START_GAP_RESET, BYTE_GAP_RESET);
    run_random(200, 1'b1);

    // let everything owed come out
    drain();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
